>>> hdl/aarm_pkg.sv
// Package: fixed-point constants and arctangent table for the rotation matrix pipeline.
package aarm_pkg;

    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 31;

    localparam logic [33:0] TWO_PI_Q30      = 34'd6746518852;
    localparam logic [33:0] FOUR_PI_Q30     = 34'd13493037704;
    localparam logic [33:0] PI_Q30          = 34'd3373259426;
    localparam logic [33:0] HALF_PI_Q30     = 34'd1686629713;
    localparam logic [33:0] THREE_HALF_PI   = 34'd5059889139;
    localparam logic [33:0] CORDIC_GAIN     = 34'd652032874;
    localparam logic [31:0] ONE_Q30         = 32'd1073741824;

    typedef logic signed [33:0] cord_t;
    typedef logic signed [31:0] q30_t;
    typedef logic signed [63:0] prod_t;

    localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2,
        32'd1
    };

endpackage

>>> hdl/axis_angle_to_rotation_matrix.sv
// Top level: rotation vector to 3x3 rotation matrix, fully pipelined.
// The pipeline has 72 register stages; out_valid is the valid bit of the last stage.
// Throughput: one transfer per cycle unless stalled; the square root, divider and CORDIC are
// unrolled into one register stage per step (32 root steps, 31 divide/CORDIC steps).
// A stall while out_valid is high freezes the whole pipeline and is passed back to the input.
// Reset clears the valid bits only; the datapath registers are not reset.
module axis_angle_to_rotation_matrix (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] vec_x,
    input  logic [31:0] vec_y,
    input  logic [31:0] vec_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] m_row0_col0,
    output logic [31:0] m_row1_col0,
    output logic [31:0] m_row2_col0,
    output logic [31:0] m_row0_col1,
    output logic [31:0] m_row1_col1,
    output logic [31:0] m_row2_col1,
    output logic [31:0] m_row0_col2,
    output logic [31:0] m_row1_col2,
    output logic [31:0] m_row2_col2
);
    import aarm_pkg::*;

    localparam int NST = 72;

    function automatic q30_t sat1(input logic signed [35:0] v);
        if (v > 36'sd1073741824)
        begin
            return q30_t'(ONE_Q30);
        end
        else if (v < -36'sd1073741824)
        begin
            return -q30_t'(ONE_Q30);
        end
        return v[31:0];
    endfunction

    logic [NST-1:0] v_reg;
    logic           adv;

    assign adv       = !(v_reg[NST-1] && out_stall);
    assign in_stall  = !adv;
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NST-2:0], in_valid};
        end
    end

    // squares and magnitudes
    logic [2:0][63:0] sq_reg;
    logic [2:0][31:0] mag0_reg;
    logic [2:0]       sgn0_reg;
    logic [2:0][31:0] vin;

    assign vin = {vec_z, vec_y, vec_x};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int d = 0; d < 3; d++)
            begin
                sq_reg[d]   <= 64'($signed(vin[d]) * $signed(vin[d]));
                sgn0_reg[d] <= vin[d][31];
                mag0_reg[d] <= vin[d][31] ? (~vin[d] + 32'd1) : vin[d];
            end
        end
    end

    // square root pipeline
    logic [63:0]      sq_n_reg   [0:SQRT_STEPS];
    logic [63:0]      sq_res_reg [0:SQRT_STEPS];
    logic [2:0][31:0] sq_mag_reg [0:SQRT_STEPS];
    logic [2:0]       sq_sgn_reg [0:SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_n_reg[0]   <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sq_res_reg[0] <= '0;
            sq_mag_reg[0] <= mag0_reg;
            sq_sgn_reg[0] <= sgn0_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        assign trial = sq_res_reg[k] + BITV;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (sq_n_reg[k] >= trial)
                begin
                    sq_n_reg[k+1]   <= sq_n_reg[k] - trial;
                    sq_res_reg[k+1] <= (sq_res_reg[k] >> 1) + BITV;
                end
                else
                begin
                    sq_n_reg[k+1]   <= sq_n_reg[k];
                    sq_res_reg[k+1] <= sq_res_reg[k] >> 1;
                end
                sq_mag_reg[k+1] <= sq_mag_reg[k];
                sq_sgn_reg[k+1] <= sq_sgn_reg[k];
            end
        end
    end

    // angle reduction modulo 2*pi
    logic [31:0]      theta;
    logic [33:0]      t4;
    logic [33:0]      r1_r_reg;
    logic [31:0]      r1_theta_reg;
    logic [2:0][31:0] r1_mag_reg;
    logic [2:0]       r1_sgn_reg;

    assign theta = sq_res_reg[SQRT_STEPS][31:0];
    assign t4    = {theta, 2'b00};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (t4 >= FOUR_PI_Q30)
            begin
                r1_r_reg <= t4 - FOUR_PI_Q30;
            end
            else if (t4 >= TWO_PI_Q30)
            begin
                r1_r_reg <= t4 - TWO_PI_Q30;
            end
            else
            begin
                r1_r_reg <= t4;
            end
            r1_theta_reg <= theta;
            r1_mag_reg   <= sq_mag_reg[SQRT_STEPS];
            r1_sgn_reg   <= sq_sgn_reg[SQRT_STEPS];
        end
    end

    // CORDIC and divider pipeline, one step per stage
    cord_t            it_x_reg     [0:CORDIC_STEPS];
    cord_t            it_y_reg     [0:CORDIC_STEPS];
    cord_t            it_z_reg     [0:CORDIC_STEPS];
    logic [2:0][61:0] it_rem_reg   [0:CORDIC_STEPS];
    logic [2:0][30:0] it_q_reg     [0:CORDIC_STEPS];
    logic [31:0]      it_theta_reg [0:CORDIC_STEPS];
    logic [2:0]       it_sgn_reg   [0:CORDIC_STEPS];
    logic             it_flip_reg  [0:CORDIC_STEPS];
    logic             it_zero_reg  [0:CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (r1_r_reg <= HALF_PI_Q30)
            begin
                it_z_reg[0]    <= $signed(r1_r_reg);
                it_flip_reg[0] <= 1'b0;
            end
            else if (r1_r_reg < THREE_HALF_PI)
            begin
                it_z_reg[0]    <= $signed(r1_r_reg - PI_Q30);
                it_flip_reg[0] <= 1'b1;
            end
            else
            begin
                it_z_reg[0]    <= $signed(r1_r_reg - TWO_PI_Q30);
                it_flip_reg[0] <= 1'b0;
            end
            it_x_reg[0]     <= $signed(CORDIC_GAIN);
            it_y_reg[0]     <= '0;
            for (int d = 0; d < 3; d++)
            begin
                it_rem_reg[0][d] <= {r1_mag_reg[d], 30'd0};
            end
            it_q_reg[0]     <= '0;
            it_theta_reg[0] <= r1_theta_reg;
            it_sgn_reg[0]   <= r1_sgn_reg;
            it_zero_reg[0]  <= (r1_theta_reg == 32'd0);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic [61:0] dsh;
        cord_t       at;
        assign dsh = {30'd0, it_theta_reg[i]} << (30 - i);
        assign at  = $signed({2'b00, ATAN_TAB[i]});
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!it_z_reg[i][33])
                begin
                    it_x_reg[i+1] <= it_x_reg[i] - (it_y_reg[i] >>> i);
                    it_y_reg[i+1] <= it_y_reg[i] + (it_x_reg[i] >>> i);
                    it_z_reg[i+1] <= it_z_reg[i] - at;
                end
                else
                begin
                    it_x_reg[i+1] <= it_x_reg[i] + (it_y_reg[i] >>> i);
                    it_y_reg[i+1] <= it_y_reg[i] - (it_x_reg[i] >>> i);
                    it_z_reg[i+1] <= it_z_reg[i] + at;
                end
                for (int d = 0; d < 3; d++)
                begin
                    if (it_rem_reg[i][d] >= dsh)
                    begin
                        it_rem_reg[i+1][d] <= it_rem_reg[i][d] - dsh;
                        it_q_reg[i+1][d]   <= it_q_reg[i][d] | (31'd1 << (30 - i));
                    end
                    else
                    begin
                        it_rem_reg[i+1][d] <= it_rem_reg[i][d];
                        it_q_reg[i+1][d]   <= it_q_reg[i][d];
                    end
                end
                it_theta_reg[i+1] <= it_theta_reg[i];
                it_sgn_reg[i+1]   <= it_sgn_reg[i];
                it_flip_reg[i+1]  <= it_flip_reg[i];
                it_zero_reg[i+1]  <= it_zero_reg[i];
            end
        end
    end

    // final sine/cosine and signed axis
    cord_t           xf;
    cord_t           yf;
    q30_t            f_c_reg;
    q30_t            f_s_reg;
    q30_t            f_w_reg [0:2];

    assign xf = it_flip_reg[CORDIC_STEPS] ? -it_x_reg[CORDIC_STEPS] : it_x_reg[CORDIC_STEPS];
    assign yf = it_flip_reg[CORDIC_STEPS] ? -it_y_reg[CORDIC_STEPS] : it_y_reg[CORDIC_STEPS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (it_zero_reg[CORDIC_STEPS])
            begin
                f_c_reg <= q30_t'(ONE_Q30);
                f_s_reg <= '0;
            end
            else
            begin
                f_c_reg <= sat1(36'(xf));
                f_s_reg <= sat1(36'(yf));
            end
            for (int d = 0; d < 3; d++)
            begin
                if (it_zero_reg[CORDIC_STEPS])
                begin
                    f_w_reg[d] <= '0;
                end
                else if (it_sgn_reg[CORDIC_STEPS][d])
                begin
                    f_w_reg[d] <= -$signed({1'b0, it_q_reg[CORDIC_STEPS][d]});
                end
                else
                begin
                    f_w_reg[d] <= $signed({1'b0, it_q_reg[CORDIC_STEPS][d]});
                end
            end
        end
    end

    // products: pairs 0:xx 1:yy 2:zz 3:xy 4:xz 5:yz; sine terms 0:sx 1:sy 2:sz
    prod_t p1_pp_reg [0:5];
    prod_t p1_ps_reg [0:2];
    q30_t  p1_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_pp_reg[0] <= f_w_reg[0] * f_w_reg[0];
            p1_pp_reg[1] <= f_w_reg[1] * f_w_reg[1];
            p1_pp_reg[2] <= f_w_reg[2] * f_w_reg[2];
            p1_pp_reg[3] <= f_w_reg[0] * f_w_reg[1];
            p1_pp_reg[4] <= f_w_reg[0] * f_w_reg[2];
            p1_pp_reg[5] <= f_w_reg[1] * f_w_reg[2];
            for (int d = 0; d < 3; d++)
            begin
                p1_ps_reg[d] <= f_w_reg[d] * f_s_reg;
            end
            p1_c_reg <= f_c_reg;
        end
    end

    // round to Q30, form 1 - cos
    localparam prod_t HALF_Q30 = 64'sd536870912;
    q30_t                p2_pp_reg [0:5];
    q30_t                p2_ps_reg [0:2];
    q30_t                p2_c_reg;
    logic signed [32:0]  p2_omc_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 6; j++)
            begin
                p2_pp_reg[j] <= 32'((p1_pp_reg[j] + HALF_Q30) >>> 30);
            end
            for (int d = 0; d < 3; d++)
            begin
                p2_ps_reg[d] <= 32'((p1_ps_reg[d] + HALF_Q30) >>> 30);
            end
            p2_c_reg   <= p1_c_reg;
            p2_omc_reg <= $signed({1'b0, ONE_Q30}) - 33'(p1_c_reg);
        end
    end

    // times (1 - cos)
    prod_t p3_m_reg  [0:5];
    q30_t  p3_ps_reg [0:2];
    q30_t  p3_c_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 6; j++)
            begin
                p3_m_reg[j] <= 64'(p2_pp_reg[j] * p2_omc_reg);
            end
            p3_ps_reg <= p2_ps_reg;
            p3_c_reg  <= p2_c_reg;
        end
    end

    // round, combine, saturate into the output register
    logic signed [35:0] rq [0:5];
    logic signed [35:0] cs;
    logic signed [35:0] sx;
    logic signed [35:0] sy;
    logic signed [35:0] sz;
    q30_t               o_reg [0:8];

    always_comb
    begin
        for (int j = 0; j < 6; j++)
        begin
            rq[j] = 36'((p3_m_reg[j] + HALF_Q30) >>> 30);
        end
        cs = 36'(p3_c_reg);
        sx = 36'(p3_ps_reg[0]);
        sy = 36'(p3_ps_reg[1]);
        sz = 36'(p3_ps_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_reg[0] <= sat1(cs + rq[0]);
            o_reg[1] <= sat1(sz + rq[3]);
            o_reg[2] <= sat1(rq[4] - sy);
            o_reg[3] <= sat1(rq[3] - sz);
            o_reg[4] <= sat1(cs + rq[1]);
            o_reg[5] <= sat1(sx + rq[5]);
            o_reg[6] <= sat1(sy + rq[4]);
            o_reg[7] <= sat1(rq[5] - sx);
            o_reg[8] <= sat1(cs + rq[2]);
        end
    end

    assign m_row0_col0 = o_reg[0];
    assign m_row1_col0 = o_reg[1];
    assign m_row2_col0 = o_reg[2];
    assign m_row0_col1 = o_reg[3];
    assign m_row1_col1 = o_reg[4];
    assign m_row2_col1 = o_reg[5];
    assign m_row0_col2 = o_reg[6];
    assign m_row1_col2 = o_reg[7];
    assign m_row2_col2 = o_reg[8];

endmodule
